// ===== rtl/slsm_pkg.sv =====
// shared types and constants for the skip list sorted multiset
// no dependencies
`default_nettype none
package slsm_pkg;

    localparam int CAPACITY   = 256;
    localparam int MAX_LEVELS = 8;
    localparam int NODE_W     = $clog2(CAPACITY);
    localparam int LINK_W     = NODE_W + 1;
    localparam int LV_W       = $clog2(MAX_LEVELS);
    localparam int CNT_W      = NODE_W + 1;
    localparam int KEY_W      = 32;

    localparam logic [1:0] FUNC_SEARCH = 2'd0;
    localparam logic [1:0] FUNC_ADD    = 2'd1;
    localparam logic [1:0] FUNC_ERASE  = 2'd2;

    typedef struct packed {
        logic [1:0]              func;
        logic signed [KEY_W-1:0] key_value;
    } in_item_t;

    typedef struct packed {
        logic found;
        logic pool_full;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic find_init;
        logic coin;
        logic pop_rd;
        logic pop_take;
        logic rd_cur;
        logic take_nx;
        logic adv;
        logic set_pred;
        logic lv_dec;
        logic lv_inc;
        logic lv_clr;
        logic rd_pred;
        logic rd_cand;
        logic wr_pred;
        logic wr_pred_n;
        logic wr_new;
        logic push;
        logic result;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       pool_empty;
        logic       coin_cond;
        logic       coin_bit;
        logic       nx_null;
        logic       key_lt;
        logic       lv_zero;
        logic       lv_eq_top;
        logic       lv_eq_h;
        logic       hit;
        logic       link_match;
        logic       out_busy;
    } status_t;

endpackage
`default_nettype wire

// ===== rtl/skiplist_sorted_multiset.sv =====
// skip list sorted multiset over a 256 node pool, eight link levels
// a refused add or an unused code goes straight to the result; a walk reads a link and compares
// keys per link followed, then records the level's predecessor; erase then reads and checks
// each level's link, rewrites matches and pushes the node; add draws coins, pops a node and links
// it per level up to its height; throughput: one item at a time, set by the single-port link memory
// walk; output register frees the input side; reset: synchronous active low, empty list, full free pool, no clearing
`default_nettype none
module skiplist_sorted_multiset (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire slsm_pkg::in_item_t  s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output slsm_pkg::out_item_t      m_item
);
    import slsm_pkg::*;

    cmd_t    cmd;
    status_t st;

    slsm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .in_func (s_item.func),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    slsm_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .st      (st),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule
`default_nettype wire

// ===== rtl/slsm_ctrl.sv =====
// sequencer for search, add and erase over the skip list datapath
// depends on slsm_pkg
`default_nettype none
module slsm_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic [1:0]       in_func,
    output logic                  s_ready,
    input  wire slsm_pkg::status_t st,
    output slsm_pkg::cmd_t        cmd
);
    import slsm_pkg::*;

    typedef enum logic [4:0] {
        IDLE, COIN, POP, POP2, F_RD, F_NX, F_KEY, F_PRED,
        E_RD, E_CHK, E_WR, E_NEXT, E_PUSH, A_RD, A_W1, A_W2, DONE
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.load      = 1'b1;
                    cmd.find_init = 1'b1;
                    if (in_func == FUNC_SEARCH || in_func == FUNC_ERASE) begin
                        state_next = F_RD;
                    end else if (in_func == FUNC_ADD && !st.pool_empty) begin
                        state_next = COIN;
                    end else begin
                        state_next = DONE;
                    end
                end
            end
            COIN: begin
                if (st.coin_cond) begin
                    cmd.coin = 1'b1;
                    if (!st.coin_bit) begin
                        state_next = POP;
                    end
                end else begin
                    state_next = POP;
                end
            end
            POP: begin
                cmd.pop_rd = 1'b1;
                state_next = POP2;
            end
            POP2: begin
                cmd.pop_take  = 1'b1;
                cmd.find_init = 1'b1;
                state_next    = F_RD;
            end
            F_RD: begin
                cmd.rd_cur = 1'b1;
                state_next = F_NX;
            end
            F_NX: begin
                cmd.take_nx = 1'b1;
                state_next  = st.nx_null ? F_PRED : F_KEY;
            end
            F_KEY: begin
                if (st.key_lt) begin
                    cmd.adv    = 1'b1;
                    state_next = F_RD;
                end else begin
                    state_next = F_PRED;
                end
            end
            F_PRED: begin
                cmd.set_pred = 1'b1;
                if (!st.lv_zero) begin
                    cmd.lv_dec = 1'b1;
                    state_next = F_RD;
                end else if (st.func == FUNC_ADD) begin
                    state_next = A_RD;
                end else if (st.func == FUNC_ERASE && st.hit) begin
                    state_next = E_RD;
                end else begin
                    state_next = DONE;
                end
            end
            E_RD: begin
                cmd.rd_pred = 1'b1;
                state_next  = E_CHK;
            end
            E_CHK: begin
                cmd.rd_cand = 1'b1;
                state_next  = st.link_match ? E_WR : E_NEXT;
            end
            E_WR: begin
                cmd.wr_pred = 1'b1;
                state_next  = E_NEXT;
            end
            E_NEXT: begin
                if (st.lv_eq_top) begin
                    state_next = E_PUSH;
                end else begin
                    cmd.lv_inc = 1'b1;
                    state_next = E_RD;
                end
            end
            E_PUSH: begin
                cmd.push   = 1'b1;
                state_next = DONE;
            end
            A_RD: begin
                cmd.rd_pred = 1'b1;
                state_next  = A_W1;
            end
            A_W1: begin
                cmd.wr_new = 1'b1;
                state_next = A_W2;
            end
            A_W2: begin
                cmd.wr_pred_n = 1'b1;
                if (st.lv_eq_h) begin
                    state_next = DONE;
                end else begin
                    cmd.lv_inc = 1'b1;
                    state_next = A_RD;
                end
            end
            DONE: begin
                if (!st.out_busy) begin
                    cmd.result = 1'b1;
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
        if (cmd.set_pred && st.lv_zero &&
            (st.func == FUNC_ADD || (st.func == FUNC_ERASE && st.hit))) begin
            cmd.lv_clr = 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/slsm_dp.sv =====
// skip list datapath: node key, link and free stack memories, walk registers
// depends on slsm_pkg
`default_nettype none
module slsm_dp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire slsm_pkg::in_item_t s_item,
    input  wire slsm_pkg::cmd_t     cmd,
    output slsm_pkg::status_t       st,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output slsm_pkg::out_item_t     m_item
);
    import slsm_pkg::*;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);
    localparam logic [LV_W-1:0]   LV_MAX    = LV_W'(MAX_LEVELS - 1);

    logic [KEY_W-1:0]  key_mem   [CAPACITY];
    logic [LINK_W-1:0] link_mem  [CAPACITY*MAX_LEVELS];
    logic [NODE_W-1:0] stack_mem [CAPACITY];

    logic [LINK_W-1:0] head_reg [MAX_LEVELS];
    logic [NODE_W-1:0] pred_reg [MAX_LEVELS];
    logic              pred_head_reg [MAX_LEVELS];

    logic [1:0]        func_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [LV_W-1:0]   lv_reg, top_reg, h_reg;
    logic [NODE_W-1:0] cur_reg, n_reg;
    logic              cur_head_reg;
    logic [LINK_W-1:0] nx_reg;
    logic [15:0]       lfsr_reg;
    logic [CNT_W-1:0]  cnt_reg, lw_reg;
    logic              hit_reg, full_reg, m_valid_reg;
    out_item_t         m_item_reg;

    logic [KEY_W-1:0]  key_rdata;
    logic [LINK_W-1:0] link_rdata;
    logic [NODE_W-1:0] stack_rdata;
    logic              rd_head_reg;

    logic [LINK_W-1:0] link_val;
    logic [CNT_W-1:0]  pop_idx;
    logic [NODE_W-1:0] pop_node;
    logic              link_rd_en, link_rd_head, link_wr_en;
    logic [NODE_W-1:0] link_rd_node, link_wr_node;
    logic [LINK_W-1:0] link_wr_data;
    logic              cur_lv_head;
    logic [NODE_W-1:0] cur_lv_pred;

    assign link_val    = rd_head_reg ? head_reg[lv_reg] : link_rdata;
    assign pop_idx     = cnt_reg - CNT_W'(1);
    assign pop_node    = (pop_idx < lw_reg) ?
                         NODE_W'(CAPACITY - 1) - pop_idx[NODE_W-1:0] : stack_rdata;
    assign cur_lv_head = pred_head_reg[lv_reg];
    assign cur_lv_pred = pred_reg[lv_reg];

    always_comb begin
        link_rd_en   = 1'b0;
        link_rd_head = 1'b0;
        link_rd_node = cur_reg;
        if (cmd.rd_cur) begin
            link_rd_en   = 1'b1;
            link_rd_head = cur_head_reg;
        end else if (cmd.rd_pred) begin
            link_rd_en   = 1'b1;
            link_rd_head = cur_lv_head;
            link_rd_node = cur_lv_pred;
        end else if (cmd.rd_cand) begin
            link_rd_en   = 1'b1;
            link_rd_node = nx_reg[NODE_W-1:0];
        end
        link_wr_en   = 1'b0;
        link_wr_node = cur_lv_pred;
        link_wr_data = link_val;
        if (cmd.wr_new) begin
            link_wr_en   = 1'b1;
            link_wr_node = n_reg;
        end else if (cmd.wr_pred && !cur_lv_head) begin
            link_wr_en = 1'b1;
        end else if (cmd.wr_pred_n && !cur_lv_head) begin
            link_wr_en   = 1'b1;
            link_wr_data = {1'b0, n_reg};
        end
    end

    // memories
    always_ff @(posedge aclk) begin
        if (link_wr_en) begin
            link_mem[{link_wr_node, lv_reg}] <= link_wr_data;
        end
        if (link_rd_en) begin
            link_rdata  <= link_mem[{link_rd_node, lv_reg}];
            rd_head_reg <= link_rd_head;
        end
        if (cmd.pop_take) begin
            key_mem[pop_node] <= key_reg;
        end
        if (cmd.take_nx) begin
            key_rdata <= key_mem[link_val[NODE_W-1:0]];
        end
        if (cmd.push) begin
            stack_mem[cnt_reg[NODE_W-1:0]] <= nx_reg[NODE_W-1:0];
        end
        if (cmd.pop_rd) begin
            stack_rdata <= stack_mem[pop_idx[NODE_W-1:0]];
        end
    end

    // walk payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_item.func;
            key_reg  <= s_item.key_value ^ {1'b1, {(KEY_W-1){1'b0}}};
            h_reg    <= '0;
            hit_reg  <= 1'b0;
            full_reg <= (s_item.func == FUNC_ADD) && (cnt_reg == '0);
        end
        if (cmd.coin && lfsr_reg[0]) begin
            h_reg <= h_reg + LV_W'(1);
        end
        if (cmd.pop_take) begin
            n_reg <= pop_node;
        end
        if (cmd.find_init) begin
            cur_head_reg <= 1'b1;
        end else if (cmd.adv) begin
            cur_head_reg <= 1'b0;
            cur_reg      <= nx_reg[NODE_W-1:0];
        end
        if (cmd.take_nx) begin
            nx_reg <= link_val;
        end
        if (cmd.set_pred) begin
            pred_reg[lv_reg]      <= cur_reg;
            pred_head_reg[lv_reg] <= cur_head_reg;
            if (lv_reg == '0) begin
                hit_reg <= !nx_reg[NODE_W] && (key_rdata == key_reg);
            end
        end
        if (cmd.pop_take) begin
            lv_reg <= top_reg;
        end else if (cmd.find_init) begin
            lv_reg <= top_reg;
        end else if (cmd.lv_clr) begin
            lv_reg <= '0;
        end else if (cmd.lv_dec) begin
            lv_reg <= lv_reg - LV_W'(1);
        end else if (cmd.lv_inc) begin
            lv_reg <= lv_reg + LV_W'(1);
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_LEVELS; i++) begin
                head_reg[i] <= NULL_LINK;
            end
            top_reg     <= '0;
            lfsr_reg    <= 16'h0001;
            cnt_reg     <= CNT_W'(CAPACITY);
            lw_reg      <= CNT_W'(CAPACITY);
            m_valid_reg <= 1'b0;
        end else begin
            if ((cmd.wr_pred || cmd.wr_pred_n) && cur_lv_head) begin
                head_reg[lv_reg] <= cmd.wr_pred ? link_val : {1'b0, n_reg};
            end
            if (cmd.coin) begin
                lfsr_reg <= (lfsr_reg >> 1) ^ (lfsr_reg[0] ? 16'hB400 : 16'h0000);
            end
            if (cmd.pop_rd && h_reg > top_reg) begin
                top_reg <= top_reg + LV_W'(1);
            end
            if (cmd.pop_take) begin
                cnt_reg <= pop_idx;
                if (pop_idx < lw_reg) begin
                    lw_reg <= pop_idx;
                end
            end else if (cmd.push) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.result) begin
            m_item_reg.found     <= hit_reg &&
                                    (func_reg == FUNC_SEARCH || func_reg == FUNC_ERASE);
            m_item_reg.pool_full <= full_reg;
        end
    end

    // in the add path pop_rd raises top before pop_take and find_init, so the walk starts at the new top
    assign st.func       = func_reg;
    assign st.pool_empty = (cnt_reg == '0);
    assign st.coin_cond  = (h_reg <= top_reg) && (h_reg < LV_MAX);
    assign st.coin_bit   = lfsr_reg[0];
    assign st.nx_null    = link_val[NODE_W];
    assign st.key_lt     = key_rdata < key_reg;
    assign st.lv_zero    = (lv_reg == '0);
    assign st.lv_eq_top  = (lv_reg == top_reg);
    assign st.lv_eq_h    = (lv_reg == h_reg);
    assign st.hit        = !nx_reg[NODE_W] && (key_rdata == key_reg);
    assign st.link_match = (link_val == nx_reg);
    assign st.out_busy   = m_valid_reg && !m_ready;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
`default_nettype wire
